FILE: rtl/bpfa_pkg.sv
`default_nettype none

package bpfa_pkg;

  // Defaults for the top level parameters
  localparam int DEF_MAX_FRAMES = 32768;
  localparam int DEF_MAX_RUN    = 256;

  // Frame numbers and counts: a 32 bit byte address rounded up gives up to
  // 2^20 frames, and start plus length needs one bit more
  localparam int FW = 22;

  // Bits in one bitmap word and in the frame count field
  localparam int BW    = 32;
  localparam int RUN_W = 9;

  localparam logic [11:0] PAGE_MASK = 12'hfff;

  // Operation codes
  localparam logic [1:0] OP_ALLOC       = 2'd0;
  localparam logic [1:0] OP_FREE        = 2'd1;
  localparam logic [1:0] OP_REGION_FREE = 2'd2;
  localparam logic [1:0] OP_REGION_USED = 2'd3;

  // Result of searching one bitmap word for the end of a free run
  typedef struct packed {
    logic             hit;
    logic [4:0]       idx;
    logic [RUN_W-1:0] run;
  } find_res_t;

endpackage

`default_nettype wire

FILE: rtl/bpfa_bitmap_ram.sv
`default_nettype none

module bpfa_bitmap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic [bpfa_pkg::BW-1:0]   rd_data,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [bpfa_pkg::BW-1:0] wr_data
);

  logic [bpfa_pkg::BW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpfa_run_finder.sv
`default_nettype none

module bpfa_run_finder (
  input  wire logic [bpfa_pkg::BW-1:0]    word,
  input  wire logic [bpfa_pkg::RUN_W-1:0] run_in,
  input  wire logic [bpfa_pkg::RUN_W-1:0] need,
  output bpfa_pkg::find_res_t             res
);

  localparam logic [31:0] ONES = 32'hffffffff;

  logic [31:0] hit;
  logic [31:0] shifted [32];
  logic [31:0] allfree;
  logic [31:0] win;
  logic [9:0]  sum [32];
  logic [4:0]  top;

  // Flag every bit at which a free run of the needed length ends
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      shifted[i] = word << (31 - i);
      win[i]     = (10'(i + 1) >= {1'b0, need}) &&
                   ((shifted[i] & ~(ONES >> need)) == 32'd0);
      allfree[i] = (word & (ONES >> (31 - i))) == 32'd0;
      sum[i]     = {1'b0, run_in} + 10'(i + 1);
      hit[i]     = ~word[i] & (win[i] | (allfree[i] & (sum[i] >= {1'b0, need})));
    end
  end

  // Pick the lowest hit and the free run left at the top of the word
  always_comb begin
    res.hit = |hit;
    res.idx = 5'd0;
    top     = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (hit[i]) begin
        res.idx = 5'(i);
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (word[i]) begin
        top = 5'(i);
      end
    end
    if (word == 32'd0) begin
      res.run = run_in + bpfa_pkg::RUN_W'(32);
    end else begin
      res.run = bpfa_pkg::RUN_W'(5'd31 - top);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_frame_allocator.sv
`default_nettype none

// Bitmap page frame allocator. One bit per 4 KiB frame (1 = used) sits in a
// single-port-write, registered-read RAM of 32 bit words. After reset the
// block sweeps the RAM to all used, one word a cycle, with busy high;
// configuration writes are taken meanwhile. An item is taken when start is
// high and busy low, and its one result appears on the out_ ports for exactly
// one cycle with out_valid; the receiver cannot stall. Items that need no RAM
// access (zero or oversize count, allocation with no managed frames,
// unaligned free, a range that is empty after clipping) give their result in
// the cycle after acceptance with busy staying low. Allocation scans the
// bitmap one word a cycle through the RAM read port, then marks the run.
// Marking (allocate, free, region ops) walks the words the range spans, one
// read and one write a cycle. With the default size a worst item scans all
// 1024 words before the marking.
module bitmap_page_frame_allocator #(
  parameter int MAX_FRAMES = bpfa_pkg::DEF_MAX_FRAMES,
  parameter int MAX_RUN    = bpfa_pkg::DEF_MAX_RUN
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_byte_address,
  input  wire logic [31:0] in_byte_length,
  input  wire logic [8:0]  in_frame_count,
  output logic             out_valid,
  output logic [31:0]      out_frame_address,
  output logic             out_success,
  output logic [15:0]      out_used_frames,
  output logic [15:0]      out_free_frames,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int WORDS = (MAX_FRAMES + 31) / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int UMAX  = (MAX_FRAMES > 65535) ? MAX_FRAMES : 65535;
  localparam int UW    = $clog2(UMAX + 1);
  localparam int FW    = bpfa_pkg::FW;
  localparam int WW    = FW - 5;
  localparam int RW    = bpfa_pkg::RUN_W;

  localparam logic [31:0] ONES = 32'hffffffff;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [15:0]   managed_r, managed_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic          iss_r, iss_nxt;
  logic          pend_r, pend_nxt;
  logic [WW-1:0] pend_w_r, pend_w_nxt;
  logic [WW-1:0] wk_w_r, wk_w_nxt;
  logic [WW-1:0] last_w_r, last_w_nxt;
  logic [FW-1:0] lo_r, lo_nxt;
  logic [FW-1:0] hi_r, hi_nxt;
  logic          set_r, set_nxt;
  logic [RW-1:0] need_r, need_nxt;
  logic [RW-1:0] run_r, run_nxt;
  logic [31:0]   addr_res_r, addr_res_nxt;
  logic          ok_res_r, ok_res_nxt;
  logic          out_valid_r;
  logic [31:0]   out_addr_r;
  logic          out_ok_r;
  logic [15:0]   out_used_r;
  logic [15:0]   out_free_r;

  logic                fin;
  logic [31:0]         fin_addr;
  logic                fin_ok;
  logic                ram_re, ram_we;
  logic [AW-1:0]       ram_raddr, ram_waddr;
  logic [31:0]         ram_rdata, ram_wdata;
  logic [FW-1:0]       eff_m;
  logic [FW-1:0]       used_ext;
  logic [FW-1:0]       used_fin;
  logic [31:0]         scan_word;
  bpfa_pkg::find_res_t fres;
  logic [FW-1:0]       hit_start;
  logic                ws_req;
  logic [FW-1:0]       ws_lo, ws_cnt, ws_hi, ws_sum, ws_hm1;
  logic                ws_go;
  logic [FW-1:0]       hm1;
  logic [4:0]          lb, hb;
  logic [31:0]         wmask;
  logic [32:0]         adr_up, len_up;

  // Saturating counter updates
  function automatic logic [FW-1:0] cnt_up(input logic [FW-1:0] u, input logic [FW-1:0] v,
                                           input logic [FW-1:0] m);
    logic [FW-1:0] s;
    s = u + v;
    return (s > m) ? m : s;
  endfunction

  function automatic logic [FW-1:0] cnt_down(input logic [FW-1:0] u, input logic [FW-1:0] v);
    return (v >= u) ? '0 : u - v;
  endfunction

  assign eff_m    = (FW'(managed_r) < FW'(MAX_FRAMES)) ? FW'(managed_r) : FW'(MAX_FRAMES);
  assign used_ext = FW'(used_r);
  assign adr_up   = {1'b0, in_byte_address} + 33'(bpfa_pkg::PAGE_MASK);
  assign len_up   = {1'b0, in_byte_length} + 33'(bpfa_pkg::PAGE_MASK);

  // Force frames at or beyond the managed count to used while scanning
  always_comb begin
    if (pend_w_r < eff_m[FW-1:5]) begin
      scan_word = ram_rdata;
    end else if (pend_w_r == eff_m[FW-1:5]) begin
      scan_word = ram_rdata | (ONES << eff_m[4:0]);
    end else begin
      scan_word = ONES;
    end
  end

  bpfa_run_finder u_finder (
    .word   (scan_word),
    .run_in (run_r),
    .need   (need_r),
    .res    (fres)
  );

  assign hit_start = {pend_w_r, fres.idx} + FW'(1) - FW'(need_r);

  // Clip a range to the managed frames and find the words it spans
  assign ws_sum = ws_lo + ws_cnt;
  assign ws_hi  = (ws_sum > eff_m) ? eff_m : ws_sum;
  assign ws_go  = ws_lo < ws_hi;
  assign ws_hm1 = ws_hi - FW'(1);

  // Bit mask of the walked range within the word being written
  assign hm1   = hi_r - FW'(1);
  assign lb    = (pend_w_r == lo_r[FW-1:5]) ? lo_r[4:0] : 5'd0;
  assign hb    = (pend_w_r == hm1[FW-1:5]) ? hm1[4:0] : 5'd31;
  assign wmask = (ONES << lb) & (ONES >> (5'd31 - hb));

  // Sequence clear, scan and walk
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    managed_nxt  = managed_r;
    used_fin     = used_ext;
    iss_nxt      = iss_r;
    pend_nxt     = 1'b0;
    pend_w_nxt   = wk_w_r;
    wk_w_nxt     = wk_w_r;
    last_w_nxt   = last_w_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    set_nxt      = set_r;
    need_nxt     = need_r;
    run_nxt      = run_r;
    addr_res_nxt = addr_res_r;
    ok_res_nxt   = ok_res_r;
    fin          = 1'b0;
    fin_addr     = addr_res_r;
    fin_ok       = ok_res_r;
    ram_re       = 1'b0;
    ram_raddr    = wk_w_r[AW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = pend_w_r[AW-1:0];
    ram_wdata    = set_r ? (ram_rdata | wmask) : (ram_rdata & ~wmask);
    ws_req       = 1'b0;
    ws_lo        = '0;
    ws_cnt       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = ONES;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          addr_res_nxt = '0;
          ok_res_nxt   = 1'b1;
          fin_addr     = '0;
          fin_ok       = 1'b1;
          unique case (in_opcode)
            bpfa_pkg::OP_ALLOC: begin
              if (in_frame_count != 9'd0 && 32'(in_frame_count) <= 32'(MAX_RUN) &&
                  eff_m != '0) begin
                state_nxt  = ST_SCAN;
                iss_nxt    = 1'b1;
                wk_w_nxt   = '0;
                last_w_nxt = WW'((eff_m - FW'(1)) >> 5);
                need_nxt   = in_frame_count;
                run_nxt    = '0;
                ok_res_nxt = 1'b0;
              end else begin
                fin    = 1'b1;
                fin_ok = 1'b0;
              end
            end
            bpfa_pkg::OP_FREE: begin
              if (in_byte_address[11:0] != 12'd0) begin
                fin    = 1'b1;
                fin_ok = 1'b0;
              end else begin
                ws_req   = 1'b1;
                ws_lo    = FW'(in_byte_address[31:12]);
                ws_cnt   = FW'(in_frame_count);
                set_nxt  = 1'b0;
                used_fin = cnt_down(used_ext, ws_cnt);
              end
            end
            bpfa_pkg::OP_REGION_FREE: begin
              ws_req   = 1'b1;
              ws_lo    = FW'(adr_up[32:12]);
              ws_cnt   = FW'(in_byte_length[31:12]);
              set_nxt  = 1'b0;
              used_fin = cnt_down(used_ext, ws_cnt);
            end
            bpfa_pkg::OP_REGION_USED: begin
              ws_req   = 1'b1;
              ws_lo    = FW'(in_byte_address[31:12]);
              ws_cnt   = FW'(len_up[32:12]);
              set_nxt  = 1'b1;
              used_fin = cnt_up(used_ext, ws_cnt, eff_m);
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re = iss_r;
        if (iss_r) begin
          wk_w_nxt = wk_w_r + WW'(1);
          iss_nxt  = wk_w_r != last_w_r;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          run_nxt = fres.run;
          if (fres.hit) begin
            if (hit_start == '0) begin
              fin       = 1'b1;
              fin_addr  = '0;
              fin_ok    = 1'b0;
              state_nxt = ST_IDLE;
            end else begin
              ws_req       = 1'b1;
              ws_lo        = hit_start;
              ws_cnt       = FW'(need_r);
              set_nxt      = 1'b1;
              used_fin     = cnt_up(used_ext, FW'(need_r), eff_m);
              addr_res_nxt = {hit_start[19:0], 12'd0};
              ok_res_nxt   = 1'b1;
              fin_addr     = {hit_start[19:0], 12'd0};
              fin_ok       = 1'b1;
            end
          end else if (pend_w_r == last_w_r) begin
            fin       = 1'b1;
            fin_addr  = '0;
            fin_ok    = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        ram_re = iss_r;
        ram_we = pend_r;
        if (iss_r) begin
          wk_w_nxt = wk_w_r + WW'(1);
          iss_nxt  = wk_w_r != last_w_r;
          pend_nxt = 1'b1;
        end
        if (pend_r && !iss_r) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // Start a walk over the range, or finish at once when it is empty
    if (ws_req) begin
      if (ws_go) begin
        state_nxt  = ST_WALK;
        lo_nxt     = ws_lo;
        hi_nxt     = ws_hi;
        wk_w_nxt   = ws_lo[FW-1:5];
        last_w_nxt = ws_hm1[FW-1:5];
        iss_nxt    = 1'b1;
        pend_nxt   = 1'b0;
      end else begin
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
    end

    used_nxt = UW'(used_fin);

    // Take a register write
    if (cfg_we) begin
      managed_nxt = cfg_wdata;
      used_nxt    = UW'(cfg_wdata);
    end
  end

  bpfa_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      managed_r   <= '0;
      used_r      <= UW'(MAX_FRAMES);
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      managed_r   <= managed_nxt;
      used_r      <= used_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= fin;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pend_w_r   <= pend_w_nxt;
    wk_w_r     <= wk_w_nxt;
    last_w_r   <= last_w_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    set_r      <= set_nxt;
    need_r     <= need_nxt;
    run_r      <= run_nxt;
    addr_res_r <= addr_res_nxt;
    ok_res_r   <= ok_res_nxt;
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (fin) begin
      out_addr_r <= fin_addr;
      out_ok_r   <= fin_ok;
      out_used_r <= used_fin[15:0];
      out_free_r <= (eff_m > used_fin) ? 16'(eff_m - used_fin) : 16'd0;
    end
  end

  assign busy              = state_r != ST_IDLE;
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_success       = out_ok_r;
  assign out_used_frames   = out_used_r;
  assign out_free_frames   = out_free_r;

`ifndef SYNTH
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result during clearing pass");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted word neither answered nor in progress");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_frame_address == 32'd0)
    else $error("failed word carries an address");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !ram_we)
    else $error("bitmap written during scan");
`endif

endmodule

`default_nettype wire
